@@ hw/rtl/mtsm_pkg.sv @@
// Shared constants, register codes and sine table function of the multi-tone mixer.
package mtsm_pkg;

  // Default parameter values
  localparam int unsigned NumTonesDefault      = 4;
  localparam int unsigned PhaseBitsDefault     = 32;
  localparam int unsigned TableAddrBitsDefault = 10;

  // Fixed field widths
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned ACTIVE_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAX_TONES  = 4;

  // Datapath widths
  localparam int unsigned AMP_W  = 22;              // table magnitude, max 4194303
  localparam int unsigned SINE_W = AMP_W + 1;       // signed tone sample
  localparam int unsigned PROD_W = SINE_W + GAIN_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 2;      // sum of up to four products
  localparam int unsigned FRAC   = 15;              // Q1.15 gain
  localparam int unsigned OUT_W  = 24;
  localparam int unsigned QUO_W  = ACC_W - FRAC;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // Output buffer
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ZERO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ONE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_TWO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_THREE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TONES = 3'd4;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'h8000;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

  // Sine series constants in unsigned Q30, and the full-scale table magnitude
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] HALF_AMP    = 64'd4194303;

  // Quarter-wave entry k of a table with 2^addr_bits steps per quadrant
  function automatic logic [AMP_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) >> addr_bits;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    term = Q30_ONE - (((x2 * term) >> 30) / 64'd156);
    term = Q30_ONE - (((x2 * term) >> 30) / 64'd110);
    term = Q30_ONE - (((x2 * term) >> 30) / 64'd72);
    term = Q30_ONE - (((x2 * term) >> 30) / 64'd42);
    term = Q30_ONE - (((x2 * term) >> 30) / 64'd20);
    term = Q30_ONE - (((x2 * term) >> 30) / 64'd6);
    s    = (x * term) >> 30;
    v    = (s * HALF_AMP + (64'd1 << 29)) >> 30;
    if (v > HALF_AMP) begin
      v = HALF_AMP;
    end
    return AMP_W'(v);
  endfunction

endpackage

@@ hw/rtl/mtsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mtsm_sine_rom.sv @@
// Quarter-wave sine table with registered read, built at elaboration.
module mtsm_sine_rom #(
  parameter int unsigned ADDR_BITS = mtsm_pkg::TableAddrBitsDefault,
  localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1
) (
  input  logic                       clk_i,
  input  logic [ADDR_BITS:0]         idx_i,
  output logic [mtsm_pkg::AMP_W-1:0] data_o
);

  logic [mtsm_pkg::AMP_W-1:0] tab [DEPTH];
  logic [mtsm_pkg::AMP_W-1:0] data_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    assign tab[k] = mtsm_pkg::sine_entry(k, ADDR_BITS);
  end

  always_ff @(posedge clk_i) begin
    data_q <= tab[idx_i];
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/multi_tone_synth_mixer.sv @@
// Top level of the four-tone phase-accumulator synthesizer and mixer.
//
// Input channel: in_valid_i / in_stall_o carry one sample tick with a phase
// step per tone. Output channel: out_valid_o / out_stall_i carry the
// saturated mixed sample and its clip flag, one result per tick, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (gains of tones zero to three, then the active tone count); write only
// while no transaction is in flight.
// Tone phases live in a small RAM; one tone is read, advanced and written
// back each cycle, so an item is worked through one tone per slot for the
// active tone count clamped to the tone count (a single idle slot when it
// is zero). A new item is taken in the final slot of the last one while
// the result buffer has room, so back-to-back items follow without a gap.
// A four-entry result buffer decouples the two sides: input transactions
// keep flowing while results wait. in_stall_o is high while the sequencer
// works through the earlier tones of a tick and whenever four results are
// in flight or waiting. Reset clears phases to zero (per-entry valid bits,
// no clearing pass), gains to 1.0 and the tone count to four.
module multi_tone_synth_mixer #(
  parameter int unsigned NUM_TONES       = mtsm_pkg::NumTonesDefault,
  parameter int unsigned PHASE_BITS      = mtsm_pkg::PhaseBitsDefault,
  parameter int unsigned TABLE_ADDR_BITS = mtsm_pkg::TableAddrBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mtsm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mtsm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mtsm_pkg::STEP_W-1:0]         phase_step_0_i,
  input  logic [mtsm_pkg::STEP_W-1:0]         phase_step_1_i,
  input  logic [mtsm_pkg::STEP_W-1:0]         phase_step_2_i,
  input  logic [mtsm_pkg::STEP_W-1:0]         phase_step_3_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mtsm_pkg::OUT_W-1:0]   mix_value_o,
  output logic                                clipped_o
);

  localparam int unsigned TONE_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
  localparam int unsigned TAB    = TABLE_ADDR_BITS;
  localparam logic [TAB:0] QSIZE = (TAB + 1)'(1 << TAB);
  localparam int unsigned ACC_W  = mtsm_pkg::ACC_W;
  localparam int unsigned QUO_W  = mtsm_pkg::QUO_W;
  localparam int unsigned OUT_W  = mtsm_pkg::OUT_W;
  localparam logic signed [QUO_W-1:0] OUT_MAX_Q = QUO_W'(mtsm_pkg::OUT_MAX);
  localparam logic signed [QUO_W-1:0] OUT_MIN_Q = QUO_W'(mtsm_pkg::OUT_MIN);

  typedef struct packed {
    logic              first;
    logic              last;
    logic              live;
    logic [TONE_W-1:0] tone;
  } slot_t;

  // ---------------------------------------------------------------- config
  logic [mtsm_pkg::GAIN_W-1:0]   gain_q [NUM_TONES];
  logic [mtsm_pkg::ACTIVE_W-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        gain_q[t] <= mtsm_pkg::GAIN_RESET;
      end
      active_q <= mtsm_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        if (cfg_idx_i == mtsm_pkg::REG_GAIN_ZERO + mtsm_pkg::CFG_IDX_W'(t)) begin
          gain_q[t] <= cfg_wdata_i[mtsm_pkg::GAIN_W-1:0];
        end
      end
      if (cfg_idx_i == mtsm_pkg::REG_ACTIVE_TONES) begin
        active_q <= cfg_wdata_i[mtsm_pkg::ACTIVE_W-1:0];
      end
    end
  end

  logic [mtsm_pkg::ACTIVE_W-1:0] n_eff;
  assign n_eff = (active_q > mtsm_pkg::ACTIVE_W'(NUM_TONES)) ?
                 mtsm_pkg::ACTIVE_W'(NUM_TONES) : active_q;

  // ---------------------------------------------------------------- issue
  logic [mtsm_pkg::STEP_W-1:0] step_in [mtsm_pkg::MAX_TONES];
  logic [PHASE_BITS-1:0]       step_q  [NUM_TONES];
  logic                        busy_q, busy_d;
  logic [TONE_W-1:0]           tone_q, tone_d;
  logic [mtsm_pkg::OUT_CNT_W-1:0] pending_q, pending_d;
  logic                        in_acc, out_pop, issue, slot_last, slot_live;

  assign step_in[0] = phase_step_0_i;
  assign step_in[1] = phase_step_1_i;
  assign step_in[2] = phase_step_2_i;
  assign step_in[3] = phase_step_3_i;

  assign issue     = busy_q;
  assign slot_live = (n_eff != '0);
  assign slot_last = !slot_live ||
                     (mtsm_pkg::ACTIVE_W'(tone_q) == n_eff - mtsm_pkg::ACTIVE_W'(1));

  // Take a new tick when the sequencer is free or on its final slot and fewer than four results are pending.
  assign in_stall_o = !((!busy_q || slot_last) &&
                        (pending_q != mtsm_pkg::OUT_CNT_W'(mtsm_pkg::OUT_DEPTH)));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    tone_d = tone_q;
    if (issue) begin
      if (slot_last) begin
        busy_d = 1'b0;
        tone_d = '0;
      end else begin
        tone_d = tone_q + TONE_W'(1);
      end
    end
    if (in_acc) begin
      busy_d = 1'b1;
    end
  end

  assign pending_d = pending_q + mtsm_pkg::OUT_CNT_W'(in_acc)
                               - mtsm_pkg::OUT_CNT_W'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      tone_q    <= '0;
      pending_q <= '0;
    end else begin
      busy_q    <= busy_d;
      tone_q    <= tone_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        step_q[t] <= step_in[t][PHASE_BITS-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic                  s1_valid_q;
  slot_t                 s1_slot_q;
  logic [PHASE_BITS-1:0] s1_step_q;
  logic                  s1_vld_q;
  logic                  fwd_q;
  logic [PHASE_BITS-1:0] fwd_data_q;
  logic [NUM_TONES-1:0]  phase_vld_q;
  logic [PHASE_BITS-1:0] ram_rdata, phase_cur, phase_new;
  logic                  ram_we;
  logic [1:0]            quad;
  logic [TAB-1:0]        tab_addr;
  logic [TAB:0]          rom_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      phase_vld_q <= '0;
    end else begin
      s1_valid_q <= issue;
      // Forward the write-back when the next read hits the same tone.
      fwd_q      <= issue && ram_we && (s1_slot_q.tone == tone_q);
      if (ram_we) begin
        phase_vld_q[s1_slot_q.tone] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_slot_q  <= '{first: (tone_q == '0), last: slot_last, live: slot_live, tone: tone_q};
    s1_step_q  <= step_q[tone_q];
    s1_vld_q   <= phase_vld_q[tone_q];
    fwd_data_q <= phase_new;
  end

  mtsm_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (NUM_TONES)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_slot_q.tone),
    .wdata_i (phase_new),
    .raddr_i (tone_q),
    .rdata_o (ram_rdata)
  );

  assign phase_cur = fwd_q ? fwd_data_q : (s1_vld_q ? ram_rdata : '0);
  assign phase_new = phase_cur + s1_step_q;
  assign ram_we    = s1_valid_q && s1_slot_q.live;
  assign quad      = phase_cur[PHASE_BITS-1 -: 2];
  assign tab_addr  = phase_cur[PHASE_BITS-3 -: TAB];
  assign rom_idx   = quad[0] ? (QSIZE - {1'b0, tab_addr}) : {1'b0, tab_addr};

  // ---------------------------------------------------------------- stage 2
  logic                              s2_valid_q;
  slot_t                             s2_slot_q;
  logic                              s2_neg_q;
  logic [mtsm_pkg::AMP_W-1:0]        rom_data;
  logic signed [mtsm_pkg::SINE_W-1:0] sine_mag, sine;
  logic signed [mtsm_pkg::GAIN_W:0]  gain_ext;
  logic signed [mtsm_pkg::PROD_W-1:0] prod_d;

  mtsm_sine_rom #(
    .ADDR_BITS (TAB)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .idx_i  (rom_idx),
    .data_o (rom_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_slot_q <= s1_slot_q;
    s2_neg_q  <= quad[1];
  end

  assign sine_mag = $signed({1'b0, rom_data});
  assign sine     = !s2_slot_q.live ? '0 : (s2_neg_q ? -sine_mag : sine_mag);
  assign gain_ext = $signed({1'b0, gain_q[s2_slot_q.tone]});
  assign prod_d   = sine * gain_ext;

  // ---------------------------------------------------------------- stage 3
  logic                               s3_valid_q;
  slot_t                              s3_slot_q;
  logic signed [mtsm_pkg::PROD_W-1:0] s3_prod_q;
  logic signed [ACC_W-1:0]            acc_q, acc_d;
  logic                               sum_valid_q;
  logic signed [ACC_W-1:0]            sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      s3_valid_q  <= s2_valid_q;
      sum_valid_q <= s3_valid_q && s3_slot_q.last;
    end
  end

  assign acc_d = (s3_slot_q.first ? '0 : acc_q) + ACC_W'(s3_prod_q);

  always_ff @(posedge clk_i) begin
    s3_slot_q <= s2_slot_q;
    s3_prod_q <= prod_d;
    if (s3_valid_q) begin
      acc_q <= acc_d;
    end
    sum_q <= acc_d;
  end

  // ---------------------------------------------------------------- stage 4
  logic signed [ACC_W-1:0] bias, biased;
  logic signed [QUO_W-1:0] quo;
  logic                    clip;
  logic [OUT_W-1:0]        res;

  // Truncate toward zero: bias negative sums before the arithmetic shift.
  assign bias   = sum_q[ACC_W-1] ? ACC_W'((1 << mtsm_pkg::FRAC) - 1) : '0;
  assign biased = sum_q + bias;
  assign quo    = QUO_W'(biased >>> mtsm_pkg::FRAC);

  always_comb begin
    clip = 1'b0;
    res  = quo[OUT_W-1:0];
    if (quo > OUT_MAX_Q) begin
      clip = 1'b1;
      res  = OUT_MAX_Q[OUT_W-1:0];
    end else if (quo < OUT_MIN_Q) begin
      clip = 1'b1;
      res  = OUT_MIN_Q[OUT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- output buffer
  logic [OUT_W-1:0]               fifo_data_q [mtsm_pkg::OUT_DEPTH];
  logic [mtsm_pkg::OUT_DEPTH-1:0] fifo_clip_q;
  logic [mtsm_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mtsm_pkg::OUT_CNT_W-1:0] count_q;

  assign out_pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (sum_valid_q) begin
        wr_ptr_q <= wr_ptr_q + mtsm_pkg::OUT_PTR_W'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + mtsm_pkg::OUT_PTR_W'(1);
      end
      count_q <= count_q + mtsm_pkg::OUT_CNT_W'(sum_valid_q)
                         - mtsm_pkg::OUT_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_q) begin
      fifo_data_q[wr_ptr_q] <= res;
      fifo_clip_q[wr_ptr_q] <= clip;
    end
  end

  assign out_valid_o = (count_q != '0);
  assign mix_value_o = $signed(fifo_data_q[rd_ptr_q]);
  assign clipped_o   = fifo_clip_q[rd_ptr_q];

endmodule

@@ hw/rtl/mtsm_checker.sv @@
// Port-level checks of the multi-tone mixer, bound to its top level.
module mtsm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [mtsm_pkg::OUT_W-1:0] mix_value_o,
  input logic                              clipped_o
);

  logic [3:0] outstanding_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Track transactions accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mix_value_o) &&
                                   $stable(clipped_o))
    else $error("output transaction changed while stalled");

  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      mix_value_o == 24'sh7FFFFF || mix_value_o == 24'sh800000)
    else $error("clip flag without a saturated sample");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outstanding_q != 4'd0)
    else $error("result without an accepted input");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 4'd4)
    else $error("more transactions in flight than the result buffer holds");

endmodule

bind multi_tone_synth_mixer mtsm_checker u_mtsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .mix_value_o (mix_value_o),
  .clipped_o   (clipped_o)
);

@@ bench/tb_multi_tone_synth_mixer.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the four-tone synthesizer and mixer, with its own sine predictor.
module tb_multi_tone_synth_mixer;

  localparam int unsigned TONES          = mtsm_pkg::NumTonesDefault;
  localparam int unsigned ADDR_BITS      = mtsm_pkg::TableAddrBitsDefault;
  localparam int unsigned QUARTER        = 1 << ADDR_BITS;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned BATCH_ITEMS    = 100;
  localparam int unsigned BATCHES        = 4;

  localparam int unsigned STEP_W     = mtsm_pkg::STEP_W;
  localparam int unsigned GAIN_W     = mtsm_pkg::GAIN_W;
  localparam int unsigned OUT_W      = mtsm_pkg::OUT_W;
  localparam int unsigned AMP_W      = mtsm_pkg::AMP_W;
  localparam int unsigned ACTIVE_W   = mtsm_pkg::ACTIVE_W;
  localparam int unsigned CFG_IDX_W  = mtsm_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = mtsm_pkg::CFG_DATA_W;
  localparam int unsigned MAX_TONES  = mtsm_pkg::MAX_TONES;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam logic [GAIN_W-1:0]    GAIN_MAX        = 16'hFFFF;
  localparam logic [GAIN_W-1:0]    GAIN_NONE       = 16'h0000;

  localparam logic [STEP_W-1:0] STEP_QUARTER = 32'h4000_0000;
  localparam logic [STEP_W-1:0] STEP_HALF    = 32'h8000_0000;
  localparam logic [STEP_W-1:0] STEP_FULL    = 32'hFFFF_FFFF;
  localparam logic [STEP_W-1:0] STEP_ENTRY   = 32'h0010_0000;
  localparam logic [STEP_W-1:0] STEP_FINE    = 32'h000F_FFFF;
  localparam logic [STEP_W-1:0] STEP_AUDIO   = 32'h0400_0000;

  typedef logic [MAX_TONES-1:0][STEP_W-1:0] tick_t;
  typedef struct {
    logic signed [OUT_W-1:0] sample;
    logic                    clip;
  } mix_result_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i    = '0;
  logic                    in_valid_i     = 1'b0;
  logic [STEP_W-1:0]       phase_step_0_i = '0;
  logic [STEP_W-1:0]       phase_step_1_i = '0;
  logic [STEP_W-1:0]       phase_step_2_i = '0;
  logic [STEP_W-1:0]       phase_step_3_i = '0;
  logic                    out_stall_i    = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [OUT_W-1:0] mix_value_o;
  logic                    clipped_o;

  // Predictor state
  logic [AMP_W-1:0]  quarter_wave [QUARTER+1];
  logic [STEP_W-1:0] phase_acc [MAX_TONES];
  logic [GAIN_W-1:0] tone_gain [MAX_TONES];
  logic [ACTIVE_W-1:0] tone_count;

  tick_t       tick_q [$];
  mix_result_t mix_expected_q [$];
  tick_t       next_tick;
  mix_result_t exp_res;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ticks_queued   = 0;
  int unsigned ticks_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned writes_done    = 0;
  int unsigned err_cnt        = 0;
  int unsigned idle_cycles    = 0;

  multi_tone_synth_mixer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .phase_step_0_i (phase_step_0_i),
    .phase_step_1_i (phase_step_1_i),
    .phase_step_2_i (phase_step_2_i),
    .phase_step_3_i (phase_step_3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mix_value_o    (mix_value_o),
    .clipped_o      (clipped_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Quarter-wave magnitude from the Q30 Horner series of sin
  function automatic logic [AMP_W-1:0] sine_magnitude(input int unsigned k);
    logic [63:0] angle;
    logic [63:0] angle_sq;
    logic [63:0] poly;
    logic [63:0] prod;
    logic [63:0] amp;
    logic [63:0] dividers [6];
    int          i;
    dividers = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    angle    = (64'(k) * mtsm_pkg::HALF_PI_Q30) >> ADDR_BITS;
    angle_sq = (angle * angle) >> 30;
    poly     = mtsm_pkg::Q30_ONE;
    for (i = 0; i < 6; i++) begin
      poly = mtsm_pkg::Q30_ONE - (((angle_sq * poly) >> 30) / dividers[i]);
    end
    prod = (angle * poly) >> 30;
    amp  = (prod * mtsm_pkg::HALF_AMP + (64'd1 << 29)) >> 30;
    if (amp > mtsm_pkg::HALF_AMP) begin
      amp = mtsm_pkg::HALF_AMP;
    end
    return AMP_W'(amp);
  endfunction

  function automatic int tone_sample(input logic [STEP_W-1:0] ph);
    logic [1:0]           quad;
    logic [ADDR_BITS-1:0] addr;
    int unsigned          idx;
    int                   mag;
    quad = ph[STEP_W-1 -: 2];
    addr = ph[STEP_W-3 -: ADDR_BITS];
    idx  = quad[0] ? QUARTER - addr : addr;
    mag  = int'(quarter_wave[idx]);
    return quad[1] ? -mag : mag;
  endfunction

  // Form one mixed sample from the current phases, then advance the enabled tones
  function automatic mix_result_t mix_tick(input tick_t steps);
    mix_result_t r;
    longint      acc;
    longint      q;
    int unsigned n;
    int unsigned t;
    n   = (tone_count > TONES) ? TONES : tone_count;
    acc = 0;
    for (t = 0; t < n; t++) begin
      acc += longint'(tone_sample(phase_acc[t])) * longint'(tone_gain[t]);
      phase_acc[t] = phase_acc[t] + steps[t];
    end
    q      = acc / (longint'(1) << mtsm_pkg::FRAC);
    r.clip = 1'b0;
    if (q > mtsm_pkg::OUT_MAX) begin
      q      = mtsm_pkg::OUT_MAX;
      r.clip = 1'b1;
    end else if (q < mtsm_pkg::OUT_MIN) begin
      q      = mtsm_pkg::OUT_MIN;
      r.clip = 1'b1;
    end
    r.sample = q[OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] random_step();
    logic [STEP_W-1:0] s;
    case ($urandom_range(3))
      0: s = $urandom_range(STEP_AUDIO);
      1: begin
        case ($urandom_range(5))
          0: s = '0;
          1: s = STEP_FULL;
          2: s = STEP_HALF;
          3: s = STEP_QUARTER;
          4: s = STEP_ENTRY;
          default: s = STEP_FINE;
        endcase
      end
      default: s = $urandom;
    endcase
    return s;
  endfunction

  task automatic push_tick(input logic [STEP_W-1:0] s0, input logic [STEP_W-1:0] s1,
                           input logic [STEP_W-1:0] s2, input logic [STEP_W-1:0] s3);
    tick_q.push_back({s3, s2, s1, s0});
    ticks_queued++;
  endtask

  task automatic push_same(input logic [STEP_W-1:0] s, input int unsigned count);
    repeat (count) push_tick(s, s, s, s);
  endtask

  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || mix_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mtsm_pkg::REG_GAIN_ZERO, mtsm_pkg::REG_GAIN_ONE,
      mtsm_pkg::REG_GAIN_TWO, mtsm_pkg::REG_GAIN_THREE: tone_gain[idx] = data;
      mtsm_pkg::REG_ACTIVE_TONES: tone_count = data[ACTIVE_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                             input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3);
    write_reg(mtsm_pkg::REG_GAIN_ZERO, g0);
    write_reg(mtsm_pkg::REG_GAIN_ONE, g1);
    write_reg(mtsm_pkg::REG_GAIN_TWO, g2);
    write_reg(mtsm_pkg::REG_GAIN_THREE, g3);
  endtask

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(3))
      0: return GAIN_NONE;
      1: return GAIN_MAX;
      2: return mtsm_pkg::GAIN_RESET;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic random_config();
    int unsigned n;
    write_gains(random_gain(), random_gain(), random_gain(), random_gain());
    n = $urandom_range(9);
    write_reg(mtsm_pkg::REG_ACTIVE_TONES,
              (n > 7) ? CFG_DATA_W'(mtsm_pkg::ACTIVE_RESET) : CFG_DATA_W'(n));
  endtask

  // Driver: present one tick per transaction, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        mix_expected_q.push_back(
          mix_tick({phase_step_3_i, phase_step_2_i, phase_step_1_i, phase_step_0_i}));
        ticks_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = tick_q.pop_front();
          phase_step_0_i <= next_tick[0];
          phase_step_1_i <= next_tick[1];
          phase_step_2_i <= next_tick[2];
          phase_step_3_i <= next_tick[3];
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expected sample
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (mix_expected_q.size() == 0) begin
          $error("unexpected result: mix_value %0d clipped %0b", mix_value_o, clipped_o);
          err_cnt++;
        end else begin
          exp_res = mix_expected_q.pop_front();
          if (mix_value_o !== exp_res.sample) begin
            $error("mix_value: expected %0d, actual %0d", exp_res.sample, mix_value_o);
            err_cnt++;
          end
          if (clipped_o !== exp_res.clip) begin
            $error("clipped: expected %0b, actual %0b", exp_res.clip, clipped_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    for (int unsigned k = 0; k <= QUARTER; k++) begin
      quarter_wave[k] = sine_magnitude(k);
    end
    for (int unsigned t = 0; t < MAX_TONES; t++) begin
      phase_acc[t] = '0;
      tone_gain[t] = mtsm_pkg::GAIN_RESET;
    end
    tone_count = mtsm_pkg::ACTIVE_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: quarter steps walk all tones through zero, peak and trough
    push_same(STEP_QUARTER, 4);
    push_same(STEP_FULL, 2);
    push_same('0, 1);
    push_same(STEP_HALF, 1);
    push_tick(STEP_ENTRY, STEP_FINE, STEP_HALF, STEP_FULL);
    push_tick(STEP_FINE, STEP_ENTRY, STEP_QUARTER, '0);
    wait_drained();

    write_gains(GAIN_MAX, GAIN_NONE, GAIN_MAX, 16'h0001);
    push_same(STEP_QUARTER, 3);
    wait_drained();

    // No tone enabled: zero out, phases frozen
    write_reg(mtsm_pkg::REG_ACTIVE_TONES, CFG_DATA_W'(0));
    push_same(STEP_QUARTER, 2);
    wait_drained();

    // Count above the tone count acts as all tones
    write_reg(mtsm_pkg::REG_ACTIVE_TONES, CFG_DATA_W'(7));
    push_same(STEP_QUARTER, 2);
    wait_drained();

    // One tone at full gain stays just inside range; then two tones run half a turn apart and cancel
    write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    write_reg(mtsm_pkg::REG_ACTIVE_TONES, CFG_DATA_W'(1));
    push_same(STEP_QUARTER, 2);
    wait_drained();
    write_reg(mtsm_pkg::REG_ACTIVE_TONES, CFG_DATA_W'(2));
    push_same(STEP_QUARTER, 2);
    wait_drained();

    // Writes to unmapped indexes must leave every setting alone
    for (int unsigned i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
      write_reg(CFG_IDX_W'(i), '0);
    end
    push_same(STEP_QUARTER, 2);
    wait_drained();

    for (int unsigned pace = 0; pace < 4; pace++) begin
      case (pace)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 70; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 70; end
        default: begin send_idle_pct <= 18; recv_stall_pct <= 18; end
      endcase
      for (int unsigned b = 0; b < BATCHES; b++) begin
        random_config();
        repeat (BATCH_ITEMS) begin
          push_tick(random_step(), random_step(), random_step(), random_step());
        end
        wait_drained();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d sample ticks, %0d results checked, %0d register writes,",
             ticks_accepted, results_seen, writes_done);
    $display("tone counts zero to seven, gain extremes and four pacing modes");
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mtsm_pkg.sv
hw/rtl/mtsm_ram.sv
hw/rtl/mtsm_sine_rom.sv
hw/rtl/multi_tone_synth_mixer.sv
hw/rtl/mtsm_checker.sv
bench/tb_multi_tone_synth_mixer.sv
